>>> design/crcfold_pkg.sv
// ============================================================================
// CRC-32C fold engine package
// Request kinds, fold and Barrett constants, and the carry-less multiply.
// ============================================================================
`default_nettype none

package crcfold_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned DataW = 64;
  localparam int unsigned KindW = 2;

  typedef logic [WordW-1:0] word_t;
  typedef logic [DataW-1:0] dword_t;

  // Request kinds carried in tuser
  typedef enum logic [KindW-1:0] {
    REQ_START = 2'd0,
    REQ_FOLD8 = 2'd1,
    REQ_WORD4 = 2'd2,
    REQ_BYTE  = 2'd3
  } req_kind_e;

  localparam word_t AllOnes = 32'hffff_ffff;
  localparam word_t KFoldLo = 32'h493c_7d27;
  localparam word_t KFoldHi = 32'hdd45_aab8;
  localparam word_t KMu     = 32'hdea7_13f1;
  localparam word_t KPoly   = 32'h05ec_76f1;

  // 32x32 -> 64 carry-less product: XOR of shifted partial products
  function automatic dword_t clmul32(input word_t a, input word_t b);
    dword_t acc;
    acc = '0;
    for (int i = 0; i < WordW; i++) begin
      if (b[i]) begin
        acc = acc ^ (dword_t'(a) << i);
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> design/crc32c_clmul_fold_engine.sv
// ============================================================================
// CRC-32C carry-less multiply fold engine
// Running reflected CRC-32C over a 64-bit fold accumulator, one shared
// 32x32 carry-less multiplier stepped by a small sequencer.
// ============================================================================
//
// Usage:
//   Slave channel: one transfer per request. tuser selects the kind (start
//   with seed, fold eight bytes, reduce four bytes, reduce one byte), tdata
//   carries the 64-bit payload (seed in bits 31:0, data bytes little-endian).
//   Master channel: exactly one transfer per request, the running CRC after
//   that request (low accumulator half XOR all-ones).
//   Steps: after the request transfer the sequencer runs the first multiply,
//   the second multiply and the output load, in that order; start skips the
//   multiplies and goes straight to the output load. The output load waits
//   while the output register is still held by the receiver. A new request
//   is taken only back in the idle state, once the previous one is through,
//   since the two dependent products share the single carry-less multiplier.
//   The slave side is ready only while the sequencer is idle. A finished
//   result sits in the output register, and a new request may be taken while
//   it waits; a request that completes while the receiver still stalls holds
//   in the output state until the register frees up.
//   Reset clears the accumulator to zero, so requests issued before any start
//   work from an all-zero remainder. Issue fold8 only while at least eight
//   more bytes follow, and close with a four-byte reduction.
//
`default_nettype none

module crc32c_clmul_fold_engine
  import crcfold_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave side
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,   // [63:0] payload
  input  wire logic [1:0]   s_axis_tuser,   // [1:0] req_type
  // master side
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata    // [31:0] crc_value
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } state_e;

  state_e    state_q, state_d;
  req_kind_e kind_q, kind_d;
  dword_t    data_q, data_d;
  dword_t    prod_q, prod_d;
  word_t     lo_q, lo_d;
  word_t     hi_q, hi_d;
  logic      ovalid_q, ovalid_d;
  word_t     ocrc_q, ocrc_d;

  // shared multiplier port
  word_t  mul_a;
  word_t  mul_k;
  dword_t mul_p;

  logic in_xfer;
  logic out_free;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ocrc_q;

  // Operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_k = '0;
    if (state_q == ST_MUL1) begin
      unique case (kind_q)
        REQ_FOLD8: begin
          mul_a = lo_q ^ data_q[WordW-1:0];
          mul_k = KFoldLo;
        end
        REQ_WORD4: begin
          mul_a = lo_q ^ data_q[WordW-1:0];
          mul_k = KMu;
        end
        REQ_BYTE: begin
          // (lo ^ byte) << 24 keeps only the low byte of the XOR
          mul_a = {lo_q[7:0] ^ data_q[7:0], 24'h0};
          mul_k = KMu;
        end
        default: begin
          mul_a = '0;
          mul_k = '0;
        end
      endcase
    end else if (state_q == ST_MUL2) begin
      if (kind_q == REQ_FOLD8) begin
        mul_a = hi_q ^ data_q[DataW-1:WordW];
        mul_k = KFoldHi;
      end else begin
        // Barrett second step on the quotient from the first product
        mul_a = prod_q[WordW-1:0];
        mul_k = KPoly;
      end
    end
  end

  assign mul_p = clmul32(mul_a, mul_k);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    data_d   = data_q;
    prod_d   = prod_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ovalid_d = ovalid_q;
    ocrc_d   = ocrc_q;

    // drop the result once the receiver takes it
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          kind_d = req_kind_e'(s_axis_tuser);
          data_d = s_axis_tdata;
          if (req_kind_e'(s_axis_tuser) == REQ_START) begin
            lo_d    = s_axis_tdata[WordW-1:0] ^ AllOnes;
            hi_d    = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        prod_d  = mul_p;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        unique case (kind_q)
          REQ_FOLD8: begin
            lo_d = mul_p[WordW-1:0] ^ prod_q[WordW-1:0];
            hi_d = mul_p[DataW-1:WordW] ^ prod_q[DataW-1:WordW];
          end
          REQ_WORD4: begin
            lo_d = hi_q ^ mul_p[DataW-1:WordW] ^ prod_q[WordW-1:0];
            hi_d = '0;
          end
          REQ_BYTE: begin
            lo_d = {8'h0, lo_q[WordW-1:8]} ^ mul_p[DataW-1:WordW] ^ prod_q[WordW-1:0];
          end
          default: begin
            lo_d = lo_q;
          end
        endcase
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ocrc_d   = lo_q ^ AllOnes;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      kind_q   <= REQ_START;
      data_q   <= '0;
      prod_q   <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      ovalid_q <= 1'b0;
      ocrc_q   <= '0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      data_q   <= data_d;
      prod_q   <= prod_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      ovalid_q <= ovalid_d;
      ocrc_q   <= ocrc_d;
    end
  end

endmodule

`default_nettype wire
